@@ sv/spa_pkg.sv @@
// ============================================================================
// spa_pkg
// Shared types for the slot pool allocator: the command bundle from the
// controller to the datapath and the status bundle that comes back.
// ============================================================================
package spa_pkg;

  // Width of a slot number on the ports.
  localparam int SLOT_W = 11;

  // Opcode values of the input beat.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Status values of the result beat.
  localparam logic ST_DONE     = 1'b0;
  localparam logic ST_INACTIVE = 1'b1;

  typedef struct packed {
    logic accept;    // latch the input beat and read the links of the target slot
    logic rel_link;  // unlink the target slot from the age list
    logic rel_push;  // push the target slot on the free stack
    logic pop_take;  // advance the free stack top past the target slot
    logic pop_link;  // link the target slot as newest, first half
    logic pop_prev;  // point the former newest slot back at the target slot
    logic done_ok;   // issue a result beat with status done
    logic done_err;  // issue a result beat with status inactive
  } ctl_cmd_t;

  typedef struct packed {
    logic in_free;     // input opcode is a free
    logic in_bad;      // input slot is out of range or was never handed out
    logic empty;       // free stack is empty
    logic op_free;     // latched opcode is a free
    logic rd_active;   // active bit read for the target slot
    logic newest_nil;  // age list is empty
  } ctl_sts_t;

endpackage

@@ sv/spa_ram.sv @@
// ============================================================================
// spa_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ============================================================================
module spa_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/spa_ctl.sv @@
// ============================================================================
// spa_ctl
// Sequencer for the slot pool allocator. Walks each operation through its
// dependent link memory reads and writes and tells the datapath what to do.
// ============================================================================
module spa_ctl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  spa_pkg::ctl_sts_t sts,
  output spa_pkg::ctl_cmd_t cmd
);

  import spa_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_REL_A = 6'b000010,
    S_REL_B = 6'b000100,
    S_POP_A = 6'b001000,
    S_POP_B = 6'b010000,
    S_POP_C = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (sts.in_free) begin
            // A free of a slot out of range or never handed out answers at once.
            if (sts.in_bad) begin
              cmd.done_err = 1'b1;
            end else begin
              state_nxt = S_REL_A;
            end
          end else if (sts.empty) begin
            state_nxt = S_REL_A;
          end else begin
            state_nxt = S_POP_A;
          end
        end
      end
      S_REL_A: begin
        if (sts.op_free && !sts.rd_active) begin
          cmd.done_err = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.rel_link = 1'b1;
          // An evicted slot is pushed and popped again at once, so the
          // push is skipped and the victim is relinked as newest.
          state_nxt = sts.op_free ? S_REL_B : S_POP_B;
        end
      end
      S_REL_B: begin
        cmd.rel_push = 1'b1;
        cmd.done_ok  = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_POP_A: begin
        cmd.pop_take = 1'b1;
        state_nxt    = S_POP_B;
      end
      S_POP_B: begin
        cmd.pop_link = 1'b1;
        if (sts.newest_nil) begin
          cmd.done_ok = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_POP_C;
        end
      end
      S_POP_C: begin
        cmd.pop_prev = 1'b1;
        cmd.done_ok  = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  a_push_after_unlink: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_REL_B |-> $past(state_r) == S_REL_A)
    else $error("push step not preceded by unlink step");

  a_prev_after_link: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP_C |-> $past(state_r) == S_POP_B)
    else $error("back link step not preceded by link step");

  a_link_source: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP_B |-> ($past(state_r) == S_POP_A || $past(state_r) == S_REL_A))
    else $error("link step entered from an unexpected step");

endmodule

@@ sv/spa_dp.sv @@
// ============================================================================
// spa_dp
// Datapath of the slot pool allocator: the link memories, the active bits,
// the free stack top, the age list ends and the result register.
// ============================================================================
module spa_dp #(
  parameter int SLOTS = 2048
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_opcode,
  input  logic [spa_pkg::SLOT_W-1:0] in_slot,
  input  spa_pkg::ctl_cmd_t          cmd,
  output spa_pkg::ctl_sts_t          sts,
  output logic                       out_valid,
  output logic [spa_pkg::SLOT_W-1:0] out_granted_slot,
  output logic                       out_evicted,
  output logic [spa_pkg::SLOT_W-1:0] out_evicted_slot,
  output logic                       out_status
);

  import spa_pkg::*;

  localparam int LW = $clog2(SLOTS + 1);
  localparam int AW = $clog2(SLOTS);
  localparam logic [LW-1:0] NIL = LW'(SLOTS);

  // Slots at or above the high water mark were never handed out. Their
  // next link is taken as the following index and a free never looks up
  // their active bit, so the memories need no clearing after reset.
  logic [LW-1:0] hw_r, hw_nxt;
  logic [LW-1:0] free_top_r, free_top_nxt;
  logic [LW-1:0] newest_r, newest_nxt;
  logic [LW-1:0] oldest_r, oldest_nxt;
  logic [LW-1:0] cur_r, cur_nxt;
  logic          op_free_r, op_free_nxt;
  logic          evict_r, evict_nxt;

  logic              out_valid_r;
  logic [SLOT_W-1:0] granted_r, granted_nxt;
  logic              evicted_r, evicted_nxt;
  logic [SLOT_W-1:0] ev_slot_r, ev_slot_nxt;
  logic              status_r, status_nxt;

  logic          empty;
  logic          slot_in_range;
  logic [LW-1:0] rd_link;
  logic          fresh;

  logic          next_we, prev_we, act_we;
  logic [AW-1:0] next_waddr, prev_waddr;
  logic [LW-1:0] next_wdata, prev_wdata;
  logic          act_wdata;
  logic [LW-1:0] next_rd, prev_rd;
  logic          act_rd;

  assign empty         = (free_top_r == NIL);
  assign slot_in_range = (32'(in_slot) < 32'(SLOTS));
  assign fresh         = (cur_r >= hw_r);

  // Target of the accepted beat: the slot to free, the oldest slot to
  // evict, or the top of the free stack.
  always_comb begin
    if (in_opcode == OP_FREE) begin
      rd_link = LW'(in_slot);
    end else if (empty) begin
      rd_link = oldest_r;
    end else begin
      rd_link = free_top_r;
    end
  end

  assign sts.in_free    = (in_opcode == OP_FREE);
  assign sts.in_bad     = !slot_in_range || (LW'(in_slot) >= hw_r);
  assign sts.empty      = empty;
  assign sts.op_free    = op_free_r;
  assign sts.rd_active  = act_rd;
  assign sts.newest_nil = (newest_r == NIL);

  // Memory write ports.
  always_comb begin
    next_we    = 1'b0;
    next_waddr = cur_r[AW-1:0];
    next_wdata = newest_r;
    prev_we    = 1'b0;
    prev_waddr = cur_r[AW-1:0];
    prev_wdata = NIL;
    act_we     = 1'b0;
    act_wdata  = 1'b0;
    if (cmd.rel_link) begin
      next_we    = (prev_rd != NIL);
      next_waddr = prev_rd[AW-1:0];
      next_wdata = next_rd;
      prev_we    = (next_rd != NIL);
      prev_waddr = next_rd[AW-1:0];
      prev_wdata = prev_rd;
    end else if (cmd.rel_push) begin
      next_we    = 1'b1;
      next_wdata = free_top_r;
      act_we     = 1'b1;
      act_wdata  = 1'b0;
    end else if (cmd.pop_link) begin
      next_we    = 1'b1;
      next_wdata = newest_r;
      prev_we    = 1'b1;
      prev_wdata = NIL;
      act_we     = 1'b1;
      act_wdata  = 1'b1;
    end else if (cmd.pop_prev) begin
      prev_we    = 1'b1;
      prev_waddr = newest_r[AW-1:0];
      prev_wdata = cur_r;
    end
  end

  // State registers.
  always_comb begin
    hw_nxt       = hw_r;
    free_top_nxt = free_top_r;
    newest_nxt   = newest_r;
    oldest_nxt   = oldest_r;
    cur_nxt      = cur_r;
    op_free_nxt  = op_free_r;
    evict_nxt    = evict_r;
    if (cmd.accept) begin
      cur_nxt     = rd_link;
      op_free_nxt = (in_opcode == OP_FREE);
      evict_nxt   = (in_opcode == OP_ALLOC) && empty;
    end
    if (cmd.rel_link) begin
      if (prev_rd == NIL) begin
        newest_nxt = next_rd;
      end
      if (next_rd == NIL) begin
        oldest_nxt = prev_rd;
      end
    end
    if (cmd.rel_push) begin
      free_top_nxt = cur_r;
    end
    if (cmd.pop_take) begin
      if (fresh) begin
        free_top_nxt = cur_r + LW'(1);
        hw_nxt       = hw_r + LW'(1);
      end else begin
        free_top_nxt = next_rd;
      end
    end
    if (cmd.pop_link && newest_r == NIL) begin
      newest_nxt = cur_r;
      oldest_nxt = cur_r;
    end
    if (cmd.pop_prev) begin
      newest_nxt = cur_r;
    end
  end

  // Result beat.
  always_comb begin
    granted_nxt = granted_r;
    evicted_nxt = evicted_r;
    ev_slot_nxt = ev_slot_r;
    status_nxt  = status_r;
    if (cmd.done_err) begin
      granted_nxt = '0;
      evicted_nxt = 1'b0;
      ev_slot_nxt = '0;
      status_nxt  = ST_INACTIVE;
    end else if (cmd.done_ok) begin
      granted_nxt = op_free_r ? '0 : SLOT_W'(cur_r);
      evicted_nxt = evict_r;
      ev_slot_nxt = evict_r ? SLOT_W'(cur_r) : '0;
      status_nxt  = ST_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r        <= '0;
      free_top_r  <= '0;
      newest_r    <= NIL;
      oldest_r    <= NIL;
      op_free_r   <= 1'b0;
      evict_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      hw_r        <= hw_nxt;
      free_top_r  <= free_top_nxt;
      newest_r    <= newest_nxt;
      oldest_r    <= oldest_nxt;
      op_free_r   <= op_free_nxt;
      evict_r     <= evict_nxt;
      out_valid_r <= cmd.done_ok || cmd.done_err;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    granted_r <= granted_nxt;
    evicted_r <= evicted_nxt;
    ev_slot_r <= ev_slot_nxt;
    status_r  <= status_nxt;
  end

  spa_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_next_mem (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .re    (cmd.accept),
    .raddr (rd_link[AW-1:0]),
    .rdata (next_rd)
  );

  spa_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_prev_mem (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .re    (cmd.accept),
    .raddr (rd_link[AW-1:0]),
    .rdata (prev_rd)
  );

  spa_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_act_mem (
    .clk   (clk),
    .we    (act_we),
    .waddr (cur_r[AW-1:0]),
    .wdata (act_wdata),
    .re    (cmd.accept),
    .raddr (rd_link[AW-1:0]),
    .rdata (act_rd)
  );

  assign out_valid        = out_valid_r;
  assign out_granted_slot = granted_r;
  assign out_evicted      = evicted_r;
  assign out_evicted_slot = ev_slot_r;
  assign out_status       = status_r;

  a_hw_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hw_r <= NIL)
    else $error("high water mark beyond pool size");

  a_list_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (newest_r == NIL) == (oldest_r == NIL))
    else $error("age list ends disagree on emptiness");

  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && in_opcode == OP_ALLOC && empty |-> hw_r == NIL && oldest_r != NIL)
    else $error("eviction while the pool is not full");

endmodule

@@ sv/slot_pool_allocator_oldest_eviction.sv @@
// ============================================================================
// slot_pool_allocator_oldest_eviction
// Fixed pool of slots with a LIFO free stack and a doubly linked age list.
// An allocate pops the free stack, or evicts the oldest active slot when
// the stack is empty; a free unlinks an active slot and pushes it back.
// ============================================================================
//
//   Channel   Ports                                    Handshake
//   input     in_opcode, in_slot                       start high, busy low
//   result    out_granted_slot, out_evicted,           out_valid, one cycle,
//             out_evicted_slot, out_status             no back pressure
//
// A free of a slot out of range or never handed out: busy stays low. A free
// of an inactive slot: ends at the link read. A free: unlink, then push. An
// allocate: take the stack top or unlink the oldest, link it as newest and,
// unless the list was empty, point the former newest back. The steps follow
// the dependent reads and writes on the single write port of each link
// memory. Reset is synchronous and needs no clearing pass: a high water mark
// stands in for the reset contents of the link and active bit memories.
// ============================================================================
module slot_pool_allocator_oldest_eviction #(
  parameter int SLOTS = 2048
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_opcode,
  input  logic [spa_pkg::SLOT_W-1:0] in_slot,
  output logic                       out_valid,
  output logic [spa_pkg::SLOT_W-1:0] out_granted_slot,
  output logic                       out_evicted,
  output logic [spa_pkg::SLOT_W-1:0] out_evicted_slot,
  output logic                       out_status
);

  import spa_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  spa_ctl u_ctl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  spa_dp #(.SLOTS(SLOTS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_opcode        (in_opcode),
    .in_slot          (in_slot),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_granted_slot (out_granted_slot),
    .out_evicted      (out_evicted),
    .out_evicted_slot (out_evicted_slot),
    .out_status       (out_status)
  );

endmodule

@@ tb/spa_result_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// spa_result_checker
// Watches the command and result channels of the slot pool allocator. Every
// accepted command beat is run through a behavioral copy of the free stack
// and the age list, and the predicted grant is queued. Each result beat is
// compared field by field against the oldest queued grant.
// ============================================================================
module spa_result_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       in_opcode,
  input  logic [spa_pkg::SLOT_W-1:0] in_slot,
  input  logic                       out_valid,
  input  logic [spa_pkg::SLOT_W-1:0] out_granted_slot,
  input  logic                       out_evicted,
  input  logic [spa_pkg::SLOT_W-1:0] out_evicted_slot,
  input  logic                       out_status,
  output int                         mismatches,
  output int                         awaited
);

  import spa_pkg::*;

  localparam int          SLOTS = 2048;
  localparam logic [11:0] NONE  = 12'd2048;

  typedef struct packed {
    logic [SLOT_W-1:0] granted;
    logic              evicted;
    logic [SLOT_W-1:0] victim;
    logic              status;
  } grant_t;

  grant_t      grants_due[$];
  logic [11:0] older_of [SLOTS];
  logic [11:0] newer_of [SLOTS];
  logic        in_use   [SLOTS];
  logic [11:0] stack_top;
  logic [11:0] newest_id;
  logic [11:0] oldest_id;

  // Takes an active slot off the age list and pushes it on the free stack.
  function automatic void retire_slot(input logic [11:0] s);
    logic [11:0] up;
    logic [11:0] down;
    up   = newer_of[s[SLOT_W-1:0]];
    down = older_of[s[SLOT_W-1:0]];
    if (up != NONE) older_of[up[SLOT_W-1:0]] = down;
    else newest_id = down;
    if (down != NONE) newer_of[down[SLOT_W-1:0]] = up;
    else oldest_id = up;
    newer_of[s[SLOT_W-1:0]] = NONE;
    older_of[s[SLOT_W-1:0]] = stack_top;
    stack_top               = s;
    in_use[s[SLOT_W-1:0]]   = 1'b0;
  endfunction

  function automatic grant_t predict_grant(input logic op, input logic [SLOT_W-1:0] slot);
    grant_t      r;
    logic [11:0] s;
    r = '0;
    if (op == OP_FREE) begin
      if (!in_use[slot]) r.status = ST_INACTIVE;
      else retire_slot({1'b0, slot});
      return r;
    end
    // An empty free stack forces the oldest active slot back onto it first.
    if (stack_top == NONE) begin
      s = oldest_id;
      if (s == NONE) return r;
      if (!in_use[s[SLOT_W-1:0]]) return r;
      retire_slot(s);
      r.evicted = 1'b1;
      r.victim  = s[SLOT_W-1:0];
    end
    s = stack_top;
    if (s == NONE) return r;
    stack_top               = older_of[s[SLOT_W-1:0]];
    older_of[s[SLOT_W-1:0]] = newest_id;
    newer_of[s[SLOT_W-1:0]] = NONE;
    if (newest_id != NONE) newer_of[newest_id[SLOT_W-1:0]] = s;
    else oldest_id = s;
    newest_id             = s;
    in_use[s[SLOT_W-1:0]] = 1'b1;
    r.granted = s[SLOT_W-1:0];
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    grant_t want;
    int     i;
    if (!rst_n) begin
      for (i = 0; i < SLOTS; i++) begin
        older_of[i] = 12'(i + 1);
        newer_of[i] = NONE;
        in_use[i]   = 1'b0;
      end
      stack_top  = '0;
      newest_id  = NONE;
      oldest_id  = NONE;
      mismatches = 0;
      grants_due.delete();
    end else begin
      if (out_valid) begin
        if (grants_due.size() == 0) begin
          $display("%0t: result beat with none expected: expected nothing, got %s",
                   $time, "a beat");
          $display("%0t:   granted %0d evicted %0d/%0d status %0d",
                   $time, out_granted_slot, out_evicted, out_evicted_slot, out_status);
          mismatches++;
        end else begin
          want = grants_due.pop_front();
          check_field("granted_slot", want.granted, out_granted_slot);
          check_field("evicted", want.evicted, out_evicted);
          check_field("evicted_slot", want.victim, out_evicted_slot);
          check_field("status", want.status, out_status);
        end
      end
      if (start && !busy) grants_due.push_back(predict_grant(in_opcode, in_slot));
    end
    awaited = grants_due.size();
  end

endmodule

@@ tb/tb_slot_pool_allocator_oldest_eviction.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_slot_pool_allocator_oldest_eviction
// Drives allocate and free commands into the slot pool allocator: a directed
// walk through the list cases, then random traffic that drains the pool,
// fills it until allocates evict, keeps it full for a while, and drains it.
// ============================================================================
module tb_slot_pool_allocator_oldest_eviction;
  import spa_pkg::*;

  localparam int SLOTS       = 2048;
  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_GAP     = 12;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_opcode;
  logic [SLOT_W-1:0] in_slot;
  logic              out_valid;
  logic [SLOT_W-1:0] out_granted_slot;
  logic              out_evicted;
  logic [SLOT_W-1:0] out_evicted_slot;
  logic              out_status;
  int                mismatches;
  int                awaited;

  // Slots believed active, oldest grant first, kept from the result beats.
  logic [SLOT_W-1:0] held[$];
  logic [SLOT_W:0]   sent_beats[$];
  logic [SLOT_W-1:0] last_freed = '0;
  int                idle_pct   = 0;
  int                beats_sent = 0;
  int                evictions  = 0;
  int                quiet      = 0;
  int                fill_beats;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  slot_pool_allocator_oldest_eviction #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_slot          (in_slot),
    .out_valid        (out_valid),
    .out_granted_slot (out_granted_slot),
    .out_evicted      (out_evicted),
    .out_evicted_slot (out_evicted_slot),
    .out_status       (out_status)
  );

  spa_result_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_slot          (in_slot),
    .out_valid        (out_valid),
    .out_granted_slot (out_granted_slot),
    .out_evicted      (out_evicted),
    .out_evicted_slot (out_evicted_slot),
    .out_status       (out_status),
    .mismatches       (mismatches),
    .awaited          (awaited)
  );

  function automatic void drop_held(input logic [SLOT_W-1:0] s);
    int i;
    for (i = 0; i < held.size(); i++) begin
      if (held[i] == s) begin
        held.delete(i);
        return;
      end
    end
  endfunction

  // Keeps the set of active slots current so that frees mostly hit live slots.
  always @(posedge clk) begin : track_pool
    logic [SLOT_W:0] beat;
    if (rst_n && out_valid && sent_beats.size() != 0) begin
      beat = sent_beats.pop_front();
      if (beat[SLOT_W] == OP_ALLOC) begin
        if (out_evicted) begin
          drop_held(out_evicted_slot);
          evictions++;
        end
        held.push_back(out_granted_slot);
      end else if (out_status == ST_DONE) begin
        drop_held(beat[SLOT_W-1:0]);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic op, input logic [SLOT_W-1:0] slot);
    int gap;
    gap = 0;
    while (idle_pct != 0 && gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      gap++;
    end
    start     <= 1'b1;
    in_opcode <= op;
    in_slot   <= slot;
    do @(posedge clk); while (busy);
    sent_beats.push_back({op, slot});
    if (op == OP_FREE) last_freed = slot;
    beats_sent++;
    unique case ((beats_sent / 150) % 3)
      0:       idle_pct = 0;
      1:       idle_pct = 58;
      default: idle_pct = 26;
    endcase
  endtask

  function automatic logic [SLOT_W-1:0] pick_free_target();
    int r;
    r = $urandom_range(99);
    if (held.size() == 0 || r < 12) return SLOT_W'($urandom_range(SLOTS - 1));
    if (r < 20) return last_freed;
    if (r < 30) return held[0];
    if (r < 40) return held[held.size() - 1];
    return held[$urandom_range(held.size() - 1)];
  endfunction

  task automatic send_random(input int alloc_pct);
    if ($urandom_range(99) < alloc_pct) send_beat(OP_ALLOC, SLOT_W'($urandom_range(SLOTS - 1)));
    else send_beat(OP_FREE, pick_free_target());
  endtask

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_opcode <= OP_ALLOC;
    in_slot   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Frees before anything was handed out, at both ends of the slot range.
    send_beat(OP_FREE, '0);
    send_beat(OP_FREE, 11'h7FF);
    // The slot field is ignored on allocates; the first goes into an empty list.
    send_beat(OP_ALLOC, 11'h7FF);
    send_beat(OP_ALLOC, 11'h000);
    send_beat(OP_ALLOC, 11'h555);
    send_beat(OP_ALLOC, 11'h2AA);
    send_beat(OP_FREE, 11'd2);
    send_beat(OP_FREE, 11'd2);
    send_beat(OP_FREE, 11'd3);
    send_beat(OP_FREE, 11'd0);
    send_beat(OP_ALLOC, 11'h3FF);
    send_beat(OP_FREE, 11'd4);
    send_beat(OP_FREE, 11'd1);
    send_beat(OP_FREE, 11'd0);
    send_beat(OP_FREE, 11'd1);
    send_beat(OP_ALLOC, 11'h400);
    send_beat(OP_ALLOC, 11'h001);

    repeat (40) send_random(50);
    repeat (40) send_random(30);
    // Fill the pool until allocates start reclaiming the oldest slot.
    fill_beats = 0;
    while (evictions == 0 && fill_beats < 5000) begin
      send_random(100);
      fill_beats++;
    end
    repeat (50) send_random(85);
    repeat (30) send_random(25);

    start <= 1'b0;
    while (awaited != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
